>>> rtl/core/mcc_pkg.sv
// mcc_pkg: shared types and constants for the magnetometer calibrate and correct block
// no dependencies
package mcc_pkg;
  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_TRACK   = 3'd1;
  localparam logic [2:0] CMD_FINISH  = 3'd2;
  localparam logic [2:0] CMD_LOAD    = 3'd3;
  localparam logic [2:0] CMD_CORRECT = 3'd4;
  localparam logic [2:0] CMD_SELF    = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OVF    = 2'd1;
  localparam logic [1:0] ST_STFAIL = 2'd2;
  localparam logic [1:0] ST_NODATA = 2'd3;

  localparam int NUM_AXES = 3;
  localparam int OUT_W    = 22;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 22'sd2097151;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -22'sd2097152;

  localparam logic signed [15:0] ST_XY_LO = -16'sd200;
  localparam logic signed [15:0] ST_XY_HI = 16'sd200;
  localparam logic signed [15:0] ST_Z_LO  = -16'sd1000;
  localparam logic signed [15:0] ST_Z_HI  = -16'sd150;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_DIV, S_OUT, S_SAT
  } state_e;
endpackage

>>> rtl/core/mcc_div.sv
// mcc_div: restoring bit-serial unsigned divider, one quotient bit a cycle
// uses mcc_pkg
module mcc_div import mcc_pkg::*; #(
  parameter int NW = 33,
  parameter int DW = 19
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [DW:0]   trial;

  always_comb begin
    trial  = {rem_q[DW-1:0], quo_q[NW-1]};
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = busy_q && (cnt_q == CW'(1));
  assign quo_o  = quo_d;
endmodule

>>> rtl/core/mcc_lane.sv
// mcc_lane: one axis lane with trackers, center, scale, divider and correction datapath
// uses mcc_pkg, mcc_div
module mcc_lane import mcc_pkg::*; #(
  parameter int SCALE_FRAC_BITS = 12,
  parameter int OUT_FRAC_BITS   = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    clr_i,
  input  logic                    track_i,
  input  logic                    finish_i,
  input  logic                    load_i,
  input  logic                    mul1_i,
  input  logic                    mul2_i,
  input  logic                    out_i,
  input  logic signed [15:0]      raw_i,
  input  logic signed [16:0]      load_center_i,
  input  logic [15:0]             load_scale_i,
  input  logic [15:0]             gain_i,
  input  logic [18:0]             sum_i,
  output logic [16:0]             range_o,
  output logic                    div_done_o,
  output logic signed [OUT_W-1:0] res_o
);
  localparam int SH = 1 + SCALE_FRAC_BITS + 16 - OUT_FRAC_BITS;
  localparam int NW = 19 + SCALE_FRAC_BITS + 1;
  // headroom keeps the shifted product wider than the output while SH stays below 37
  localparam int PW = 18 + 16 + 17 + 8;

  logic signed [15:0] max_q, min_q;
  logic signed [16:0] center_q;
  logic [15:0]        scale_q;
  logic signed [17:0] diff_q;
  logic signed [34:0] p1_q;
  logic signed [PW-1:0] p2_q;
  logic [18:0]        den;
  logic [NW-1:0]      num, quo;
  logic               div_done;
  logic signed [PW-1:0] rnd;
  logic signed [PW-SH-1:0] shf;

  assign range_o = 17'($signed({max_q[15], max_q}) - $signed({min_q[15], min_q}));
  assign den     = 19'({2'b0, range_o}) + 19'({1'b0, range_o, 1'b0});
  // numerator already holds the half-denominator for round half up
  assign num     = ({NW'(sum_i)} << (SCALE_FRAC_BITS + 1)) + NW'(den);

  mcc_div #(.NW(NW), .DW(20)) u_div (
    .clk_i, .rst_ni, .start_i(finish_i), .num_i(num), .den_i({den, 1'b0}),
    .done_o(div_done), .quo_o(quo)
  );
  assign div_done_o = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= -16'sd32768;
      min_q    <= 16'sd32767;
      center_q <= '0;
      scale_q  <= 16'(1 << SCALE_FRAC_BITS);
    end else begin
      if (clr_i) begin
        max_q <= -16'sd32768;
        min_q <= 16'sd32767;
      end else if (track_i) begin
        if (raw_i > max_q) max_q <= raw_i;
        if (raw_i < min_q) min_q <= raw_i;
      end
      if (finish_i) center_q <= 17'($signed({max_q[15], max_q}) + $signed({min_q[15], min_q}));
      if (div_done) begin
        if (range_o == '0) scale_q <= 16'hFFFF;
        else if (quo > NW'(65535)) scale_q <= 16'hFFFF;
        else scale_q <= quo[15:0];
      end
      if (load_i) begin
        center_q <= load_center_i;
        scale_q  <= load_scale_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul1_i) begin
      diff_q <= 18'($signed({raw_i, 1'b0})) - 18'(center_q);
    end
    if (mul2_i) p1_q <= 35'(diff_q * $signed({1'b0, scale_q}));
    if (out_i) p2_q  <= PW'(p1_q * $signed({1'b0, gain_i}));
  end

  always_comb begin
    rnd = p2_q + (PW'(1) <<< (SH - 1));
    shf = rnd[PW-1:SH];
    if (shf > $signed((PW-SH)'(OUT_MAX))) res_o = OUT_MAX;
    else if (shf < $signed({{(PW-SH-OUT_W){1'b1}}, OUT_MIN})) res_o = OUT_MIN;
    else res_o = shf[OUT_W-1:0];
  end
endmodule

>>> rtl/core/magnetometer_calibrate_and_correct.sv
// magnetometer_calibrate_and_correct: top level, command sequencer and merge of three axis lanes
// uses mcc_pkg and mcc_lane; mcc_div sits inside each lane
// clear/track/load/self-test and overflowed or empty items answer from the first command
// state; correct passes three registered stages (center subtract, scale multiply, gain
// multiply), then rounding and saturation; finish runs a bit-serial divider per lane, one
// quotient bit a cycle; one item at a time; reset: trackers cleared, scales 1.0, gain 9830
module magnetometer_calibrate_and_correct import mcc_pkg::*; #(
  parameter int SCALE_FRAC_BITS = 12,
  parameter int OUT_FRAC_BITS   = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[2:0], axis_select[4:3], raw_x[20:5], raw_y[36:21], raw_z[52:37],
  // sensor_overflow[53], load_center[70:54], load_scale[86:71]
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x[21:0], out_y[43:22], out_z[65:44], status[67:66]
  output logic [71:0]  m_axis_tdata
);
  state_e state_q, state_d;
  logic [15:0] gain_q;
  logic [87:0] item_q;
  logic        seen_q;
  logic [71:0] out_q;
  logic        outv_q;
  logic [2:0]  cmd;
  logic        ovf;
  logic signed [15:0] raw [NUM_AXES];
  logic [16:0] rng [NUM_AXES];
  logic [NUM_AXES-1:0] done;
  logic signed [OUT_W-1:0] res [NUM_AXES];
  logic        acc, fin_go, st_pass;
  logic [1:0]  status;
  logic [18:0] sum;
  logic [71:0] res_word;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && !outv_q;
  assign cmd = item_q[2:0];
  assign ovf = item_q[53];
  assign raw[0] = item_q[20:5];
  assign raw[1] = item_q[36:21];
  assign raw[2] = item_q[52:37];
  assign sum = 19'(rng[0]) + 19'(rng[1]) + 19'(rng[2]);
  assign fin_go = (state_q == S_MUL1) && cmd == CMD_FINISH && seen_q;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    mcc_lane #(.SCALE_FRAC_BITS(SCALE_FRAC_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_lane (
      .clk_i, .rst_ni,
      .clr_i   (state_q == S_MUL1 && cmd == CMD_CLEAR),
      .track_i (state_q == S_MUL1 && cmd == CMD_TRACK && !ovf),
      .finish_i(fin_go),
      .load_i  (state_q == S_MUL1 && cmd == CMD_LOAD && item_q[4:3] == 2'(g)),
      .mul1_i  (state_q == S_MUL1),
      .mul2_i  (state_q == S_MUL2),
      .out_i   (state_q == S_OUT),
      .raw_i   (raw[g]),
      .load_center_i(item_q[70:54]),
      .load_scale_i (item_q[86:71]),
      .gain_i  (gain_q),
      .sum_i   (sum),
      .range_o (rng[g]),
      .div_done_o(done[g]),
      .res_o   (res[g])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (acc) state_d = S_MUL1;
      S_MUL1: begin
        if (fin_go) state_d = S_DIV;
        else if (cmd == CMD_CORRECT && !ovf) state_d = S_MUL2;
        else state_d = S_IDLE;
      end
      S_MUL2: state_d = S_OUT;
      S_DIV:  if (&done) state_d = S_IDLE;
      S_OUT:  state_d = S_SAT;
      S_SAT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    st_pass = raw[0] >= ST_XY_LO && raw[0] <= ST_XY_HI && raw[1] >= ST_XY_LO &&
              raw[1] <= ST_XY_HI && raw[2] >= ST_Z_LO && raw[2] <= ST_Z_HI;
    status = ST_OK;
    case (cmd) inside
      CMD_TRACK, CMD_CORRECT: if (ovf) status = ST_OVF;
      CMD_FINISH: if (!seen_q) status = ST_NODATA;
      CMD_SELF: begin
        if (ovf) status = ST_OVF;
        else if (!st_pass) status = ST_STFAIL;
      end
      default: status = ST_OK;
    endcase
    res_word = {4'b0, status, 66'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      gain_q  <= 16'd9830;
      seen_q  <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) gain_q <= cfg_wdata_i;
      if (state_q == S_MUL1 && cmd == CMD_CLEAR) seen_q <= 1'b0;
      if (state_q == S_MUL1 && cmd == CMD_TRACK && !ovf) seen_q <= 1'b1;
      if (outv_q && m_axis_tready) outv_q <= 1'b0;
      if ((state_q == S_MUL1 && state_d == S_IDLE) || (state_q == S_DIV && &done)) begin
        outv_q <= 1'b1;
      end
      if (state_q == S_SAT) outv_q <= 1'b1;
    end
  end

  // the product register is filled at the end of the out state and read by saturation in the sat state
  always_ff @(posedge clk_i) begin
    if (acc) item_q <= s_axis_tdata;
    if (state_q == S_MUL1 && state_d == S_IDLE) out_q <= res_word;
    if (state_q == S_DIV && &done) out_q <= {4'b0, ST_OK, 66'b0};
    if (state_q == S_SAT) out_q <= {4'b0, ST_OK, res[2], res[1], res[0]};
  end

  assign m_axis_tvalid = outv_q;
  assign m_axis_tdata  = out_q;
endmodule

>>> rtl/core/mcc_checker.sv
// mcc_checker: port-level checks for the magnetometer calibrate and correct block
// uses mcc_pkg; bound to the top level
module mcc_checker import mcc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  // a pending result blocks new items
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("item taken with result pending");
  // after an accept ready is low, and the item is never answered in the same cycle
  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after accept");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[71:68] == 4'b0) else $error("pad bits set");
endmodule

bind magnetometer_calibrate_and_correct mcc_checker u_mcc_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);

>>> verif/magnetometer_calibrate_and_correct_tb.sv
// testbench for magnetometer_calibrate_and_correct: directed table then random items,
// every result checked against a local predictor of tracker, calibration and correction
// uses mcc_pkg and the rtl only
module magnetometer_calibrate_and_correct_tb;
  import mcc_pkg::*;

  localparam int SFB = 12;
  localparam int OFB = 4;

  typedef struct packed {
    logic [15:0]        load_scale;
    logic signed [16:0] load_center;
    logic               ovf;
    logic signed [15:0] rz;
    logic signed [15:0] ry;
    logic signed [15:0] rx;
    logic [1:0]         sel;
    logic [2:0]         cmd;
  } mag_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [21:0] oz;
    logic signed [21:0] oy;
    logic signed [21:0] ox;
  } mag_res_t;

  typedef struct {
    mag_item_t item;
    logic      has_exp;
    mag_res_t  exp_res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  magnetometer_calibrate_and_correct dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  int signed   trk_max[3], trk_min[3], cal_center[3];
  int unsigned cal_scale[3];
  bit          seen;
  int unsigned gain;

  mag_res_t expected_q[$];
  int       errors = 0;
  int       send_idle_pct = 0, recv_idle_pct = 0;
  int       idle_cycles = 0;

  function automatic longint floor_sh(longint p, int sh);
    return p >>> sh;
  endfunction

  function automatic logic signed [21:0] corrected(longint raw, int a);
    int     sh;
    longint d, p, r;
    sh = 1 + SFB + 16 - OFB;
    d = 2 * raw - longint'(cal_center[a]);
    p = d * longint'(cal_scale[a]) * longint'(gain);
    r = floor_sh(p + (longint'(1) << (sh - 1)), sh);
    if (r > 2097151) r = 2097151;
    if (r < -2097152) r = -2097152;
    return r[21:0];
  endfunction

  function automatic mag_res_t predict_result(mag_item_t it);
    mag_res_t    res;
    longint      raw[3], rng[3], sum, q, den;
    res = '0;
    raw[0] = it.rx; raw[1] = it.ry; raw[2] = it.rz;
    case (it.cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < 3; i++) begin trk_max[i] = -32768; trk_min[i] = 32767; end
        seen = 0;
      end
      CMD_TRACK: begin
        if (it.ovf) res.status = ST_OVF;
        else begin
          for (int i = 0; i < 3; i++) begin
            if (raw[i] > trk_max[i]) trk_max[i] = int'(raw[i]);
            if (raw[i] < trk_min[i]) trk_min[i] = int'(raw[i]);
          end
          seen = 1;
        end
      end
      CMD_FINISH: begin
        if (!seen) res.status = ST_NODATA;
        else begin
          sum = 0;
          for (int i = 0; i < 3; i++) begin
            rng[i] = longint'(trk_max[i]) - trk_min[i];
            sum += rng[i];
          end
          for (int i = 0; i < 3; i++) begin
            cal_center[i] = trk_max[i] + trk_min[i];
            if (rng[i] == 0) cal_scale[i] = 65535;
            else begin
              den = 3 * rng[i];
              q = ((sum << SFB) + den / 2) / den;
              cal_scale[i] = (q > 65535) ? 32'd65535 : 32'(q);
            end
          end
        end
      end
      CMD_LOAD: begin
        if (it.sel < 3) begin
          cal_center[it.sel] = it.load_center;
          cal_scale[it.sel] = it.load_scale;
        end
      end
      CMD_CORRECT: begin
        if (it.ovf) res.status = ST_OVF;
        else begin
          res.ox = corrected(raw[0], 0);
          res.oy = corrected(raw[1], 1);
          res.oz = corrected(raw[2], 2);
        end
      end
      CMD_SELF: begin
        if (it.ovf) res.status = ST_OVF;
        else if (it.rx < ST_XY_LO || it.rx > ST_XY_HI || it.ry < ST_XY_LO ||
                 it.ry > ST_XY_HI || it.rz < ST_Z_LO || it.rz > ST_Z_HI)
          res.status = ST_STFAIL;
      end
      default: ;
    endcase
    return res;
  endfunction

  // receiver: random stall, check at rising edge
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    mag_res_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[67:0];
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.ox !== want.ox)
            $display("%0t: out_x exp %0d got %0d", $time, want.ox, got.ox);
          if (got.oy !== want.oy)
            $display("%0t: out_y exp %0d got %0d", $time, want.oy, got.oy);
          if (got.oz !== want.oz)
            $display("%0t: out_z exp %0d got %0d", $time, want.oz, got.oz);
          if (got.status !== want.status)
            $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
          if (got !== want) errors++;
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // tvalid stays high between back-to-back items and drops only while the sender idles
  task automatic send_item(mag_item_t it, logic has_exp, mag_res_t exp_res);
    mag_res_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, it};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_result(it);
    if (has_exp && pred !== exp_res) begin
      $display("%0t: table row exp %h predictor %h", $time, exp_res, pred);
      errors++;
    end
    expected_q.push_back(pred);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_gain(logic [15:0] g);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= g;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    gain = g;
  endtask

  function automatic mag_item_t mk(logic [2:0] c, int x, int y, int z, bit o = 0,
                                   logic [1:0] s = 0, int ctr = 0, int sc = 0);
    mag_item_t it;
    it.cmd = c; it.sel = s; it.rx = 16'(x); it.ry = 16'(y); it.rz = 16'(z); it.ovf = o;
    it.load_center = 17'(ctr); it.load_scale = 16'(sc);
    return it;
  endfunction

  function automatic mag_res_t st(logic [1:0] s);
    mag_res_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  function automatic mag_item_t random_item();
    mag_item_t it;
    int        k;
    it = mag_item_t'(87'({$urandom, $urandom, $urandom}));
    k = $urandom_range(99);
    // mostly sensible command mix with bounded sample spread
    if (k < 35) it.cmd = CMD_TRACK;
    else if (k < 65) it.cmd = CMD_CORRECT;
    else if (k < 72) it.cmd = CMD_FINISH;
    else if (k < 80) it.cmd = CMD_LOAD;
    else if (k < 88) it.cmd = CMD_SELF;
    else if (k < 93) it.cmd = CMD_CLEAR;
    else it.cmd = 3'($urandom_range(7));
    it.ovf = ($urandom_range(9) == 0);
    if ($urandom_range(3) != 0) begin
      it.rx = 16'($signed(16'($urandom_range(1200))) - 600);
      it.ry = 16'($signed(16'($urandom_range(1200))) - 600);
      it.rz = 16'($signed(16'($urandom_range(1200))) - 900);
    end
    if (it.load_center == 17'sh0ffff) it.load_center = '0;
    return it;
  endfunction

  row_t dir_tab[$];
  int   phase;

  initial begin
    mag_item_t it;
    for (int i = 0; i < 3; i++) begin
      trk_max[i] = -32768; trk_min[i] = 32767; cal_center[i] = 0; cal_scale[i] = 4096;
    end
    seen = 0;
    gain = 9830;
    dir_tab = '{
      '{mk(CMD_FINISH, 0, 0, 0), 1'b1, st(ST_NODATA)},
      '{mk(CMD_CORRECT, 0, 0, 0), 1'b1, st(ST_OK)},
      '{mk(CMD_CORRECT, 32767, -32768, 1), 1'b0, st(ST_OK)},
      '{mk(CMD_TRACK, 5, 5, 5, 1), 1'b1, st(ST_OVF)},
      '{mk(CMD_FINISH, 0, 0, 0), 1'b1, st(ST_NODATA)},
      '{mk(CMD_SELF, 0, 0, -500), 1'b1, st(ST_OK)},
      '{mk(CMD_SELF, 200, -200, -150), 1'b1, st(ST_OK)},
      '{mk(CMD_SELF, 201, 0, -500), 1'b1, st(ST_STFAIL)},
      '{mk(CMD_SELF, 0, -201, -500), 1'b1, st(ST_STFAIL)},
      '{mk(CMD_SELF, 0, 0, -1001), 1'b1, st(ST_STFAIL)},
      '{mk(CMD_SELF, 0, 0, -149), 1'b1, st(ST_STFAIL)},
      '{mk(CMD_SELF, 0, 0, -500, 1), 1'b1, st(ST_OVF)},
      '{mk(CMD_CORRECT, 1, 1, 1, 1), 1'b1, st(ST_OVF)},
      '{mk(CMD_TRACK, 32767, -32768, 100), 1'b1, st(ST_OK)},
      '{mk(CMD_TRACK, -32768, 32767, 100), 1'b1, st(ST_OK)},
      '{mk(CMD_FINISH, 0, 0, 0), 1'b1, st(ST_OK)},
      '{mk(CMD_CORRECT, 32767, -32768, 100), 1'b0, st(ST_OK)},
      '{mk(CMD_LOAD, 0, 0, 0, 0, 0, -65536, 65535), 1'b1, st(ST_OK)},
      '{mk(CMD_LOAD, 0, 0, 0, 0, 1, 65534, 0), 1'b1, st(ST_OK)},
      '{mk(CMD_LOAD, 0, 0, 0, 0, 3, 123, 456), 1'b1, st(ST_OK)},
      '{mk(CMD_CORRECT, 32767, -32768, -32768), 1'b0, st(ST_OK)},
      '{mk(CMD_CORRECT, -32768, 32767, 32767), 1'b0, st(ST_OK)},
      '{mk(3'd6, 1, 2, 3), 1'b1, st(ST_OK)},
      '{mk(3'd7, 1, 2, 3, 1), 1'b1, st(ST_OK)},
      '{mk(CMD_CLEAR, 0, 0, 0), 1'b1, st(ST_OK)}
    };
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].has_exp, dir_tab[i].exp_res);
    write_gain(16'hffff);
    send_item(mk(CMD_CORRECT, 32767, -32768, 77), 1'b0, '0);
    write_gain(16'h0000);
    send_item(mk(CMD_CORRECT, 32767, -32768, 77), 1'b1, st(ST_OK));
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 64 : 0;
      recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 28 : 0;
      write_gain(phase == 2 ? 16'd9830 : 16'($urandom));
      for (int n = 0; n < 600; n++) begin
        it = random_item();
        send_item(it, 1'b0, '0);
        // once per phase, hold off until the block is empty
        if (n == 300) begin
          s_axis_tvalid <= 1'b0;
          while (expected_q.size() != 0) @(negedge clk_i);
        end
      end
    end
    drain_results();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

>>> magnetometer_calibrate_and_correct.f
rtl/core/mcc_pkg.sv
rtl/core/mcc_div.sv
rtl/core/mcc_lane.sv
rtl/core/magnetometer_calibrate_and_correct.sv
rtl/core/mcc_checker.sv
verif/magnetometer_calibrate_and_correct_tb.sv
